// ----- rtl/ttl_pkg.sv -----
// Shared types, codes and constants of the transfer task lifecycle controller.
package ttl_pkg;

    // Commands carried in the input tuser
    typedef enum logic [3:0] {
        ACT_START    = 4'd0,
        ACT_PAUSE    = 4'd1,
        ACT_RESUME   = 4'd2,
        ACT_FLUSH    = 4'd3,
        ACT_KILL     = 4'd4,
        ACT_FAULT    = 4'd5,
        ACT_DISRUPT  = 4'd6,
        ACT_PREPARE  = 4'd7,
        ACT_ENQUEUE  = 4'd8,
        ACT_DEQUEUE  = 4'd9,
        ACT_COMPLETE = 4'd10,
        ACT_CLEAR    = 4'd11
    } t_action;

    // Emitted action codes
    typedef enum logic [2:0] {
        EM_NONE     = 3'd0,
        EM_PREPARE  = 3'd1,
        EM_RUN      = 3'd2,
        EM_STOP     = 3'd3,
        EM_FLUSH    = 3'd4,
        EM_CANCEL   = 3'd5,
        EM_FINALIZE = 3'd6
    } t_emit;

    // Job phase, one-hot inside the block
    typedef enum logic [5:0] {
        PH_QUEUED   = 6'b000001,
        PH_WAITING  = 6'b000010,
        PH_ACTIVE   = 6'b000100,
        PH_PAUSED   = 6'b001000,
        PH_COMPLETE = 6'b010000,
        PH_KILLED   = 6'b100000
    } t_phase;

    // Phase codes as reported on the result stream
    localparam logic [2:0] JS_QUEUED   = 3'd0;
    localparam logic [2:0] JS_WAITING  = 3'd1;
    localparam logic [2:0] JS_ACTIVE   = 3'd2;
    localparam logic [2:0] JS_PAUSED   = 3'd3;
    localparam logic [2:0] JS_COMPLETE = 3'd4;
    localparam logic [2:0] JS_KILLED   = 3'd5;

    localparam int          THR_WIDTH = 48;
    localparam logic [47:0] THR_RESET = 48'd52428800;   // 50 MiB

    // APB register word index
    localparam logic REG_THRESHOLD = 1'b0;

    // Everything one command produces, handed to the result buffer
    typedef struct packed {
        logic       accepted;
        t_emit      emit0;
        t_emit      emit1;
        logic       two;        // second result follows the first
        logic [2:0] job_state;
        logic       changed;
        logic       error;
        logic       overflow;
    } t_result;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        unique case (ph)
            PH_QUEUED:   code = JS_QUEUED;
            PH_WAITING:  code = JS_WAITING;
            PH_ACTIVE:   code = JS_ACTIVE;
            PH_PAUSED:   code = JS_PAUSED;
            PH_COMPLETE: code = JS_COMPLETE;
            PH_KILLED:   code = JS_KILLED;
            default:     code = JS_QUEUED;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/ttl_job.sv -----
// Job state registers and the per-command update logic.
module ttl_job #(
    parameter int COUNT_WIDTH = 32,
    parameter int BYTES_WIDTH = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic [3:0]                     i_action,
    input  logic [31:0]                    i_amount,
    input  logic                           i_fin,
    input  logic [ttl_pkg::THR_WIDTH-1:0]  i_threshold,
    output ttl_pkg::t_result               o_res
);

    localparam int SW = ((BYTES_WIDTH > 32) ? BYTES_WIDTH : 32) + 1;
    localparam int TW = (BYTES_WIDTH > ttl_pkg::THR_WIDTH) ? BYTES_WIDTH : ttl_pkg::THR_WIDTH;
    localparam logic [BYTES_WIDTH-1:0] BMAX = {BYTES_WIDTH{1'b1}};

    ttl_pkg::t_phase        r_phase, n_phase;
    logic [BYTES_WIDTH-1:0] r_qb, n_qb;
    logic [COUNT_WIDTH-1:0] r_enq, n_enq;
    logic [COUNT_WIDTH-1:0] r_deq, n_deq;
    logic [COUNT_WIDTH-1:0] r_exp, n_exp;
    logic                   r_fault, n_fault;
    logic                   r_held, n_held;

    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_diff;
    logic [BYTES_WIDTH-1:0] w_qb_add;
    logic [BYTES_WIDTH-1:0] w_qb_sub;
    logic [COUNT_WIDTH-1:0] w_enq_inc;
    logic [COUNT_WIDTH-1:0] w_deq_inc;
    logic w_runnable;
    logic w_ok;
    logic w_two;
    ttl_pkg::t_emit w_em0, w_em1;

    assign w_sum    = SW'(r_qb) + SW'(i_amount);
    assign w_qb_add = (w_sum > SW'(BMAX)) ? BMAX : w_sum[BYTES_WIDTH-1:0];
    assign w_diff   = SW'(r_qb) - SW'(i_amount);
    assign w_qb_sub = (SW'(i_amount) >= SW'(r_qb)) ? '0 : w_diff[BYTES_WIDTH-1:0];
    assign w_enq_inc = r_enq + COUNT_WIDTH'(1);
    assign w_deq_inc = r_deq + COUNT_WIDTH'(1);
    assign w_runnable = (r_phase == ttl_pkg::PH_ACTIVE) || (r_phase == ttl_pkg::PH_WAITING) ||
                        (r_phase == ttl_pkg::PH_PAUSED);

    always_comb begin
        n_phase = r_phase;
        n_qb    = r_qb;
        n_enq   = r_enq;
        n_deq   = r_deq;
        n_exp   = r_exp;
        n_fault = r_fault;
        n_held  = r_held;
        w_ok    = 1'b1;
        w_em0   = ttl_pkg::EM_NONE;
        w_em1   = ttl_pkg::EM_NONE;
        w_two   = 1'b0;
        unique case (ttl_pkg::t_action'(i_action))
            ttl_pkg::ACT_START: begin
                if (r_phase != ttl_pkg::PH_QUEUED) begin
                    w_ok = 1'b0;
                end else begin
                    w_em0   = ttl_pkg::EM_PREPARE;
                    w_em1   = ttl_pkg::EM_RUN;
                    w_two   = 1'b1;
                    n_phase = ttl_pkg::PH_WAITING;
                end
            end
            ttl_pkg::ACT_PAUSE: begin
                if (r_phase != ttl_pkg::PH_QUEUED && r_phase != ttl_pkg::PH_ACTIVE &&
                    r_phase != ttl_pkg::PH_WAITING) begin
                    w_ok = 1'b0;
                end else begin
                    if (r_phase == ttl_pkg::PH_ACTIVE) w_em0 = ttl_pkg::EM_STOP;
                    n_phase = ttl_pkg::PH_PAUSED;
                end
            end
            ttl_pkg::ACT_RESUME: begin
                if (r_phase != ttl_pkg::PH_PAUSED) begin
                    w_ok = 1'b0;
                end else if (r_exp != '0) begin
                    w_em0   = ttl_pkg::EM_RUN;
                    n_phase = ttl_pkg::PH_WAITING;
                end else begin
                    n_phase = ttl_pkg::PH_QUEUED;
                end
            end
            ttl_pkg::ACT_FLUSH: begin
                if (!w_runnable) w_ok = 1'b0;
                else             w_em0 = ttl_pkg::EM_FLUSH;
            end
            ttl_pkg::ACT_KILL: begin
                if (r_phase == ttl_pkg::PH_KILLED) begin
                    w_ok = 1'b0;
                end else begin
                    if (r_phase == ttl_pkg::PH_ACTIVE || r_phase == ttl_pkg::PH_WAITING) begin
                        w_em0 = ttl_pkg::EM_STOP;
                        w_em1 = ttl_pkg::EM_CANCEL;
                        w_two = 1'b1;
                    end else if (r_phase == ttl_pkg::PH_PAUSED) begin
                        w_em0 = ttl_pkg::EM_CANCEL;
                    end
                    n_phase = ttl_pkg::PH_KILLED;
                end
            end
            ttl_pkg::ACT_FAULT: begin
                if (!w_runnable) begin
                    w_ok = 1'b0;
                end else begin
                    if (r_phase != ttl_pkg::PH_PAUSED) begin
                        w_em0 = ttl_pkg::EM_STOP;
                        w_em1 = ttl_pkg::EM_CANCEL;
                        w_two = 1'b1;
                    end else begin
                        w_em0 = ttl_pkg::EM_CANCEL;
                    end
                    n_fault = 1'b1;
                    n_phase = ttl_pkg::PH_COMPLETE;
                end
            end
            ttl_pkg::ACT_DISRUPT: begin
                if (r_phase != ttl_pkg::PH_ACTIVE) w_ok = 1'b0;
                else                               n_phase = ttl_pkg::PH_WAITING;
            end
            ttl_pkg::ACT_PREPARE: begin
                if (r_exp != '0) w_ok = 1'b0;
                else             n_exp = COUNT_WIDTH'(i_amount);
            end
            ttl_pkg::ACT_ENQUEUE: begin
                if (!w_runnable) begin
                    w_ok = 1'b0;
                end else begin
                    n_qb  = w_qb_add;
                    n_enq = w_enq_inc;
                    if (r_phase == ttl_pkg::PH_ACTIVE) begin
                        if (w_enq_inc == r_exp) begin
                            w_em0 = ttl_pkg::EM_STOP;
                        end else if (TW'(w_qb_add) >= TW'(i_threshold)) begin
                            n_held  = 1'b1;
                            w_em0   = ttl_pkg::EM_STOP;
                            n_phase = ttl_pkg::PH_WAITING;
                        end
                    end else if (r_phase == ttl_pkg::PH_WAITING) begin
                        n_phase = ttl_pkg::PH_ACTIVE;
                    end
                end
            end
            ttl_pkg::ACT_DEQUEUE: begin
                if (!w_runnable) begin
                    w_ok = 1'b0;
                end else begin
                    n_qb  = w_qb_sub;
                    n_deq = w_deq_inc;
                    if (r_phase == ttl_pkg::PH_ACTIVE) begin
                        if (w_deq_inc == r_exp) begin
                            w_em0 = ttl_pkg::EM_FINALIZE;
                        end else if (r_held && w_qb_sub == '0) begin
                            n_held  = 1'b0;
                            w_em0   = ttl_pkg::EM_RUN;
                            n_phase = ttl_pkg::PH_WAITING;
                        end
                    end
                end
            end
            ttl_pkg::ACT_COMPLETE: begin
                if (!i_fin) w_ok = 1'b0;
                else        n_phase = ttl_pkg::PH_COMPLETE;
            end
            ttl_pkg::ACT_CLEAR: begin
                n_phase = ttl_pkg::PH_QUEUED;
                n_qb    = '0;
                n_enq   = '0;
                n_deq   = '0;
                n_exp   = '0;
                n_fault = 1'b0;
                n_held  = 1'b0;
            end
            default: w_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_res.accepted  = w_ok;
        o_res.emit0     = w_em0;
        o_res.emit1     = w_em1;
        o_res.two       = w_two;
        o_res.job_state = ttl_pkg::phase_code(n_phase);
        o_res.changed   = (n_phase != r_phase);
        o_res.error     = n_fault;
        o_res.overflow  = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ttl_pkg::PH_QUEUED;
            r_qb    <= '0;
            r_enq   <= '0;
            r_deq   <= '0;
            r_exp   <= '0;
            r_fault <= 1'b0;
            r_held  <= 1'b0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_qb    <= n_qb;
            r_enq   <= n_enq;
            r_deq   <= n_deq;
            r_exp   <= n_exp;
            r_fault <= n_fault;
            r_held  <= n_held;
        end
    end

endmodule

// ----- rtl/ttl_obuf.sv -----
// Result register that plays out the one or two results of a command.
module ttl_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ttl_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data,
    output logic [2:0]       o_user,
    output logic             o_last
);

    logic             r_valid;
    logic             r_second;
    ttl_pkg::t_result r_res;
    logic             w_fire;

    assign o_last  = !r_res.two || r_second;
    assign w_fire  = r_valid && i_ready;
    assign o_free  = !r_valid || (w_fire && o_last);
    assign o_valid = r_valid;
    assign o_user  = r_second ? r_res.emit1 : r_res.emit0;
    assign o_data  = {1'b0, r_res.overflow, r_res.error, r_res.changed,
                      r_res.job_state, r_res.accepted};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (i_load) begin
            r_valid  <= 1'b1;
            r_second <= 1'b0;
        end else if (w_fire) begin
            r_valid  <= !o_last;
            r_second <= !o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_res <= i_res;
    end

endmodule

// ----- rtl/transfer_task_lifecycle_fsm_core.sv -----
// Top level of the transfer task lifecycle controller.
//
//  channel   dir  handshake                      transaction
//  s_axis    in   s_axis_tvalid/s_axis_tready    one command
//  m_axis    out  m_axis_tvalid/m_axis_tready    one result (1 or 2 per command)
//  apb       in   psel/penable/pwrite, pready=1  threshold register write/read
//
// A command lands in the input register, is evaluated against the job state once
// the result register is free, and its one or two results are loaded into the
// result register; one result leaves per cycle while m_axis_tready is high.
// Input stays open while a result waits, as long as the input register is empty.
// Reset (synchronous, active low) returns the job to queued with all counters
// zero and the threshold to 50 MiB. A stall on m_axis holds the result and backs
// up into s_axis_tready after one command is buffered.
module transfer_task_lifecycle_fsm_core #(
    parameter int COUNT_WIDTH = 32,
    parameter int BYTES_WIDTH = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // commands
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] amount
    input  logic [4:0]  s_axis_tuser,   // [3:0] action, [4] finish_is_finalize
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] accepted, [3:1] job_state,
                                        // [4] state_changed, [5] error_flag,
                                        // [6] overflow_flag, [7] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] emitted
    output logic        m_axis_tlast,   // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // Input register
    logic        r_in_valid;
    logic [3:0]  r_act;
    logic [31:0] r_amt;
    logic        r_fin;

    logic [ttl_pkg::THR_WIDTH-1:0] r_thr;

    ttl_pkg::t_result w_res;
    logic w_free;
    logic w_go;
    logic w_in_fire;

    assign w_go          = r_in_valid && w_free;
    assign s_axis_tready = !r_in_valid || w_free;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_act <= s_axis_tuser[3:0];
            r_fin <= s_axis_tuser[4];
            r_amt <= s_axis_tdata;
        end
    end

    // APB: pready tied high; one register at word 0, 48 bits wide, read zero-extended to 64
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ttl_pkg::THR_RESET;
        end else if (psel && penable && pwrite && pready && paddr[3] == ttl_pkg::REG_THRESHOLD) begin
            r_thr <= pwdata[ttl_pkg::THR_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[3] == ttl_pkg::REG_THRESHOLD) prdata = 64'(r_thr);
    end

    ttl_job #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .BYTES_WIDTH (BYTES_WIDTH)
    ) u_job (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_action    (r_act),
        .i_amount    (r_amt),
        .i_fin       (r_fin),
        .i_threshold (r_thr),
        .o_res       (w_res)
    );

    ttl_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_go),
        .i_res   (w_res),
        .o_free  (w_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

    // A first-of-two result always carries a real action
    a_first_has_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser != ttl_pkg::EM_NONE))
        else $error("first of two results carries no action");

    // The second result follows right after the first is taken
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("second result missing");

    // A refused command gives exactly one result and no action
    a_refused_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |->
        (m_axis_tlast && m_axis_tuser == ttl_pkg::EM_NONE))
        else $error("refused command with an action");

    // Once faulted, the job is complete or killed until a clear
    a_error_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |->
        (m_axis_tdata[3:1] == ttl_pkg::JS_COMPLETE || m_axis_tdata[3:1] == ttl_pkg::JS_KILLED))
        else $error("error flag outside a finished job");

endmodule

// ----- tb/transfer_task_lifecycle_fsm_checker.sv -----
// Scoreboard for the transfer job lifecycle controller: predicts and checks the result stream.
`timescale 1ns / 1ps

module transfer_task_lifecycle_fsm_checker
    import ttl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,    // [31:0] amount
    input  logic [4:0]  i_s_tuser,    // [3:0] action, [4] finish_is_finalize
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,    // [0] accepted, [3:1] job_state, [4] state_changed,
                                      // [5] error_flag, [6] overflow_flag, [7] zero
    input  logic [2:0]  i_m_tuser,    // [2:0] emitted
    input  logic        i_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    input  logic [63:0] i_prdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [3:0] ADDR_THRESHOLD = 4'(8 * REG_THRESHOLD);

    typedef struct {
        logic       accepted;
        t_emit      emitted;
        logic [2:0] job_state;
        logic       changed;
        logic       error;
        logic       overflow;
        logic       last;
    } t_job_result;

    t_job_result expected_results[$];
    int          fail_count = 0;
    int          n_pending  = 0;

    // Shadow of the job state
    logic [47:0] threshold;
    logic [2:0]  phase;
    logic [47:0] queued_bytes;
    logic [31:0] enq_count;
    logic [31:0] deq_count;
    logic [31:0] want_buffers;
    logic        fault_seen;
    logic        held;

    function automatic void clear_job();
        phase        = JS_QUEUED;
        queued_bytes = '0;
        enq_count    = '0;
        deq_count    = '0;
        want_buffers = '0;
        fault_seen   = 1'b0;
        held         = 1'b0;
    endfunction

    function automatic bit job_runnable();
        return phase == JS_ACTIVE || phase == JS_WAITING || phase == JS_PAUSED;
    endfunction

    // Apply one command to the shadow state and queue the results it should produce
    function automatic void predict_command(input logic [3:0] act, input logic [31:0] amt,
                                            input logic fin);
        logic [2:0]  ph_prev;
        logic        ok;
        t_emit       em [2];
        int          n_em;
        int          n_out;
        logic [48:0] sum;
        t_job_result r;
        ph_prev = phase;
        ok      = 1'b1;
        n_em    = 0;
        em[0]   = EM_NONE;
        em[1]   = EM_NONE;
        case (act)
            ACT_START: begin
                if (phase != JS_QUEUED) begin
                    ok = 1'b0;
                end else begin
                    em[0] = EM_PREPARE;
                    em[1] = EM_RUN;
                    n_em  = 2;
                    phase = JS_WAITING;
                end
            end
            ACT_PAUSE: begin
                if (phase != JS_QUEUED && phase != JS_ACTIVE && phase != JS_WAITING) begin
                    ok = 1'b0;
                end else begin
                    if (phase == JS_ACTIVE) begin
                        em[0] = EM_STOP;
                        n_em  = 1;
                    end
                    phase = JS_PAUSED;
                end
            end
            ACT_RESUME: begin
                if (phase != JS_PAUSED) begin
                    ok = 1'b0;
                end else if (want_buffers != 0) begin
                    em[0] = EM_RUN;
                    n_em  = 1;
                    phase = JS_WAITING;
                end else begin
                    phase = JS_QUEUED;
                end
            end
            ACT_FLUSH: begin
                if (!job_runnable()) begin
                    ok = 1'b0;
                end else begin
                    em[0] = EM_FLUSH;
                    n_em  = 1;
                end
            end
            ACT_KILL: begin
                if (phase == JS_KILLED) begin
                    ok = 1'b0;
                end else begin
                    if (phase == JS_ACTIVE || phase == JS_WAITING) begin
                        em[0] = EM_STOP;
                        em[1] = EM_CANCEL;
                        n_em  = 2;
                    end else if (phase == JS_PAUSED) begin
                        em[0] = EM_CANCEL;
                        n_em  = 1;
                    end
                    phase = JS_KILLED;
                end
            end
            ACT_FAULT: begin
                if (!job_runnable()) begin
                    ok = 1'b0;
                end else begin
                    if (phase != JS_PAUSED) begin
                        em[n_em] = EM_STOP;
                        n_em++;
                    end
                    em[n_em] = EM_CANCEL;
                    n_em++;
                    fault_seen = 1'b1;
                    phase      = JS_COMPLETE;
                end
            end
            ACT_DISRUPT: begin
                if (phase != JS_ACTIVE) ok = 1'b0;
                else phase = JS_WAITING;
            end
            ACT_PREPARE: begin
                if (want_buffers != 0) ok = 1'b0;
                else want_buffers = amt;
            end
            ACT_ENQUEUE: begin
                if (!job_runnable()) begin
                    ok = 1'b0;
                end else begin
                    sum          = {1'b0, queued_bytes} + {17'd0, amt};
                    queued_bytes = sum[48] ? '1 : sum[47:0];   // saturate at full range
                    enq_count    = enq_count + 32'd1;
                    if (phase == JS_ACTIVE) begin
                        if (enq_count == want_buffers) begin
                            em[0] = EM_STOP;
                            n_em  = 1;
                        end else if (queued_bytes >= threshold) begin
                            held  = 1'b1;
                            em[0] = EM_STOP;
                            n_em  = 1;
                            phase = JS_WAITING;
                        end
                    end else if (phase == JS_WAITING) begin
                        phase = JS_ACTIVE;
                    end
                end
            end
            ACT_DEQUEUE: begin
                if (!job_runnable()) begin
                    ok = 1'b0;
                end else begin
                    if ({16'd0, amt} >= queued_bytes) queued_bytes = '0;
                    else queued_bytes = queued_bytes - {16'd0, amt};
                    deq_count = deq_count + 32'd1;
                    if (phase == JS_ACTIVE) begin
                        if (deq_count == want_buffers) begin
                            em[0] = EM_FINALIZE;
                            n_em  = 1;
                        end else if (held && queued_bytes == 0) begin
                            held  = 1'b0;
                            em[0] = EM_RUN;
                            n_em  = 1;
                            phase = JS_WAITING;
                        end
                    end
                end
            end
            ACT_COMPLETE: begin
                if (!fin) ok = 1'b0;
                else phase = JS_COMPLETE;
            end
            ACT_CLEAR: clear_job();
            default: ok = 1'b0;
        endcase

        n_out = (n_em > 0) ? n_em : 1;
        for (int k = 0; k < n_out; k++) begin
            r.accepted  = ok;
            r.emitted   = (n_em > 0) ? em[k] : EM_NONE;
            r.job_state = phase;
            r.changed   = (phase != ph_prev);
            r.error     = fault_seen;
            r.overflow  = held;
            r.last      = (k == n_out - 1);
            expected_results.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_job_result head;
        if (!i_rst_n) begin
            threshold = THR_RESET;
            clear_job();
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no command outstanding: tdata %h tuser %h",
                           i_m_tdata, i_m_tuser);
                    fail_count++;
                end else begin
                    head = expected_results.pop_front();
                    check_field("accepted", head.accepted, i_m_tdata[0]);
                    check_field("emitted", head.emitted, i_m_tuser);
                    check_field("job_state", head.job_state, i_m_tdata[3:1]);
                    check_field("state_changed", head.changed, i_m_tdata[4]);
                    check_field("error_flag", head.error, i_m_tdata[5]);
                    check_field("overflow_flag", head.overflow, i_m_tdata[6]);
                    check_field("last", head.last, i_m_tlast);
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_command(i_s_tuser[3:0], i_s_tdata, i_s_tuser[4]);
            if (i_psel && i_penable && i_pready && i_paddr == ADDR_THRESHOLD) begin
                if (i_pwrite) threshold = i_pwdata[47:0];
                else check_field("prdata", threshold, i_prdata[47:0]);
            end
        end
        n_pending = expected_results.size();
    end

    assign o_fail_count = fail_count;
    assign o_pending    = n_pending;

endmodule

// ----- tb/tb_transfer_task_lifecycle_fsm_core.sv -----
// Testbench top for the transfer job lifecycle controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_transfer_task_lifecycle_fsm_core;
    import ttl_pkg::*;

    localparam logic [3:0] ADDR_THRESHOLD = 4'(8 * REG_THRESHOLD);
    // Longest legitimate quiet spell is the receiver hold-off (HOLD_CYCLES); give ample margin.
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] amount
    logic [4:0]  s_axis_tuser  = '0;    // [3:0] action, [4] finish_is_finalize
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [63:0] pwdata        = '0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;          // [0] accepted, [3:1] job_state, [4] state_changed,
                                        // [5] error_flag, [6] overflow_flag, [7] zero
    logic [2:0]  m_axis_tuser;          // [2:0] emitted
    logic        m_axis_tlast;
    logic [63:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;

    // Stimulus bookkeeping
    logic [47:0] thr_now     = THR_RESET;   // threshold currently programmed, scales amounts
    int          items_sent  = 0;
    int          burst_left  = 1;
    bit          hold_req    = 1'b0;        // top asks the receiver for a long hold-off
    int          idle_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    transfer_task_lifecycle_fsm_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    transfer_task_lifecycle_fsm_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Random finish_is_finalize bit
    function automatic logic rand_fin();
        return 1'($urandom_range(0, 1));
    endfunction

    // ------------------------------------------------------------------
    // Command sender. Offers one transaction and holds it until accepted.
    // Valid stays high across a burst; at the end of a burst it drops for
    // a random gap. The gap always includes a clock edge, so valid never
    // gets two nonblocking writes in the same time step.
    // ------------------------------------------------------------------
    task automatic issue(input logic [3:0] act, input logic [31:0] amt, input logic fin);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= amt;
        s_axis_tuser  <= {fin, act};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            // mostly short bursts, now and then a long gap-free run
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // Stop offering and wait for the result stream to drain. The first edge
    // lets the scoreboard absorb a transaction accepted in this very step;
    // the trailing edges add a margin after the drain.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Program the overflow threshold while idle, then read it back
    // (psel stays high between the two transfers).
    task automatic set_threshold(input logic [47:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_THRESHOLD;
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        thr_now = value;
    endtask

    // Byte sizes scaled to the threshold so overflow engages and drains,
    // plus the extremes and full-range noise.
    function automatic logic [31:0] pick_amount();
        logic [31:0] span;
        span = (thr_now > 48'h7FFF_FFFF) ? 32'hFFFF_FFFF : {thr_now[30:0], 1'b0};
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return $urandom_range(0, span >> 2);
            default: return $urandom_range(0, span);
        endcase
    endfunction

    // One well-formed job: usually clear and prepare, then start, a body of queue
    // traffic with occasional control commands, then mostly an ending.
    task automatic run_session();
        int body;
        int r;
        if ($urandom_range(0, 4) != 0) issue(ACT_CLEAR, pick_amount(), rand_fin());
        r = $urandom_range(0, 9);
        if (r < 7)       issue(ACT_PREPARE, $urandom_range(1, 12), rand_fin());
        else if (r == 7) issue(ACT_PREPARE, 32'd0, rand_fin());
        else if (r == 8) issue(ACT_PREPARE, $urandom, rand_fin());
        issue(ACT_START, pick_amount(), rand_fin());
        body = $urandom_range(4, 30);
        repeat (body) begin
            r = $urandom_range(0, 99);
            if (r < 40)      issue(ACT_ENQUEUE, pick_amount(), rand_fin());
            else if (r < 75) issue(ACT_DEQUEUE, pick_amount(), rand_fin());
            else if (r < 80) issue(ACT_PAUSE, pick_amount(), rand_fin());
            else if (r < 86) issue(ACT_RESUME, pick_amount(), rand_fin());
            else if (r < 90) issue(ACT_DISRUPT, pick_amount(), rand_fin());
            else if (r < 94) issue(ACT_FLUSH, pick_amount(), rand_fin());
            else if (r < 96) issue(ACT_PREPARE, $urandom_range(1, 12), rand_fin());
            else if (r < 97) issue(ACT_START, pick_amount(), rand_fin());
            else if (r < 98) issue(ACT_FAULT, pick_amount(), rand_fin());
            else if (r < 99) issue(ACT_KILL, pick_amount(), rand_fin());
            else             issue(ACT_COMPLETE, pick_amount(), rand_fin());
        end
        case ($urandom_range(0, 3))
            0:       issue(ACT_COMPLETE, pick_amount(), 1'b1);
            1:       issue(ACT_KILL, pick_amount(), rand_fin());
            2:       issue(ACT_FAULT, pick_amount(), rand_fin());
            default: ;
        endcase
    endtask

    // Mostly sessions, the rest raw commands including undefined codes.
    // Optionally requests a receiver hold-off halfway through.
    task automatic run_random(input int n, input bit with_hold);
        int stop_at;
        bit hold_done;
        stop_at   = items_sent + n;
        hold_done = !with_hold;
        while (items_sent < stop_at) begin
            if (!hold_done && items_sent > stop_at - n / 2) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                run_session();
            end else begin
                repeat ($urandom_range(1, 8))
                    issue(4'($urandom_range(0, 15)), pick_amount(), rand_fin());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result receiver: random runs of stall / coin-flip / always-ready,
    // and on request one long hold-off so the block backs up into s_axis.
    // ------------------------------------------------------------------
    initial begin : receiver
        int   mode;
        int   len;
        logic rdy;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(1, 20);
                repeat (len) begin
                    case (mode)
                        0:       rdy = 1'b0;
                        1:       rdy = 1'($urandom_range(0, 1));
                        default: rdy = 1'b1;
                    endcase
                    m_axis_tready <= rdy;
                    @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk at the reset threshold: refusals, undefined codes,
        // both prepare cases, the full start/run/finalize path, pause and
        // resume, kill twice, complete twice, clear, pause-from-queued, fault.
        issue(ACT_COMPLETE, 32'd0, 1'b0);            // complete without finalize: refused
        issue(4'd12, 32'hFFFF_FFFF, 1'b1);           // undefined codes
        issue(4'd15, 32'd0, 1'b0);
        issue(ACT_RESUME, 32'd0, 1'b0);              // not paused
        issue(ACT_FLUSH, 32'd0, 1'b0);               // not runnable
        issue(ACT_PREPARE, 32'd3, 1'b0);
        issue(ACT_PREPARE, 32'd5, 1'b0);             // count already set
        issue(ACT_START, 32'd0, 1'b0);               // prepare + run list
        issue(ACT_START, 32'd0, 1'b0);               // refused
        issue(ACT_ENQUEUE, 32'd0, 1'b0);             // waiting -> active
        issue(ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b0);
        issue(ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b1);     // waiting -> active, no stop
        issue(ACT_DEQUEUE, 32'd0, 1'b0);
        issue(ACT_DEQUEUE, 32'hFFFF_FFFF, 1'b0);
        issue(ACT_DEQUEUE, 32'hFFFF_FFFF, 1'b0);     // drains to zero, finalize
        issue(ACT_PAUSE, 32'd0, 1'b0);
        issue(ACT_RESUME, 32'd0, 1'b0);
        issue(ACT_FLUSH, 32'd0, 1'b0);
        issue(ACT_DISRUPT, 32'd0, 1'b0);             // only legal when active
        issue(ACT_KILL, 32'd0, 1'b0);
        issue(ACT_KILL, 32'd0, 1'b0);                // already killed
        issue(ACT_COMPLETE, 32'd0, 1'b1);
        issue(ACT_COMPLETE, 32'd0, 1'b1);            // already complete, no change
        issue(ACT_CLEAR, 32'hFFFF_FFFF, 1'b1);
        issue(ACT_PAUSE, 32'd0, 1'b0);               // queued -> paused
        issue(ACT_FAULT, 32'd0, 1'b0);               // fault while paused: cancel only

        // Minimum threshold: a non-final active enqueue trips overflow once bytes are queued
        set_threshold(48'd1);
        run_random(350, 1'b0);

        // Small threshold with a receiver hold-off to fill the block
        set_threshold(48'($urandom_range(64, 4096)));
        run_random(450, 1'b1);
        wait_idle();                                 // sender pause until drained
        run_random(100, 1'b0);

        // Maximum threshold: a run of full-size enqueues builds a large
        // byte total that stays below the ceiling, then one dequeue and a clear.
        set_threshold(48'hFFFF_FFFF_FFFF);
        issue(ACT_CLEAR, 32'd0, 1'b0);
        issue(ACT_PREPARE, 32'd0, 1'b0);
        issue(ACT_START, 32'd0, 1'b0);
        issue(ACT_ENQUEUE, 32'd0, 1'b0);
        repeat (40) issue(ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b0);
        issue(ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b0);
        issue(ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b0);
        issue(ACT_DEQUEUE, 32'hFFFF_FFFF, 1'b0);
        issue(ACT_CLEAR, 32'd0, 1'b0);
        run_random(200, 1'b0);

        // Arbitrary wide threshold
        set_threshold({16'($urandom_range(1, 65535)), 32'($urandom)});
        run_random(150, 1'b0);

        // Back to the reset value, with another hold-off
        set_threshold(THR_RESET);
        run_random(300, 1'b1);

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ttl_pkg.sv
rtl/ttl_job.sv
rtl/ttl_obuf.sv
rtl/transfer_task_lifecycle_fsm_core.sv
tb/transfer_task_lifecycle_fsm_checker.sv
tb/tb_transfer_task_lifecycle_fsm_core.sv
